@@ hdl/fuzzy_level_controller_top_defines.svh @@
`ifndef FUZZY_LEVEL_CONTROLLER_TOP_DEFINES_SVH
`define FUZZY_LEVEL_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/flc_pkg.sv @@
package flc_pkg;

    localparam int OPEN_LOW  = 0;
    localparam int OPEN_HIGH = 100;
    localparam int OPEN_STEP = 1;
    localparam int STEP      = (OPEN_STEP < 1) ? 1 : OPEN_STEP;
    localparam int NPTS      = (OPEN_HIGH - OPEN_LOW) / STEP + 1;
    localparam int CHUNK     = 8;
    localparam int NSTG      = (NPTS + CHUNK - 1) / CHUNK;

    localparam int NUM_W = 24;
    localparam int DEN_W = 16;
    localparam int Q_W   = 15;

    localparam logic [2:0] REG_TARGET = 3'd0;

    typedef struct packed {
        logic [8:0] gn;
        logic [8:0] gz;
        logic [8:0] gp;
    } t_grade;

    // floor(x/5) for x <= 1280
    function automatic logic [8:0] div5(input logic [10:0] x);
        logic [22:0] m;
        begin
            m = 23'(x) * 23'd3277;
            return m[22:14];
        end
    endfunction

    function automatic int pt(input int j);
        return OPEN_LOW + j * STEP;
    endfunction

    function automatic logic [8:0] set_close(input int p);
        int v;
        begin
            if (p > -25 && p <= 0)     v = ((25 + p) * 256) / 25;
            else if (p > 0 && p < 25)  v = ((25 - p) * 256) / 25;
            else                       v = 0;
            return 9'(v);
        end
    endfunction

    function automatic logic [8:0] set_open(input int p);
        int v;
        begin
            if (p > 0 && p < 50) v = (p * 256) / 50;
            else if (p >= 50)    v = 256;
            else                 v = 0;
            return 9'(v);
        end
    endfunction

    function automatic logic [8:0] min9(input logic [8:0] a, input logic [8:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [8:0] max9(input logic [8:0] a, input logic [8:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ hdl/flc_front.sv @@
module flc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [15:0]   i_target,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_level,
    output logic                 o_valid,
    input  logic                 i_ready,
    output flc_pkg::t_grade      o_grade
);

    logic            r_vld;
    flc_pkg::t_grade r_grade;
    flc_pkg::t_grade n_grade;
    logic signed [16:0] e;

    assign e = 17'(i_target) - 17'(i_level);

    always_comb begin
        n_grade = '0;
        if (e >= -17'sd240 && e <= -17'sd160)
            n_grade.gn = 9'd256;
        else if (e > -17'sd160 && e < 0)
            n_grade.gn = flc_pkg::div5(11'((-e) * 17'sd8));

        if (e > -17'sd80 && e <= 0)
            n_grade.gz = flc_pkg::div5(11'((17'sd80 + e) * 17'sd16));
        else if (e > 0 && e < 17'sd80)
            n_grade.gz = flc_pkg::div5(11'((17'sd80 - e) * 17'sd16));

        if (e > 0 && e < 17'sd160)
            n_grade.gp = flc_pkg::div5(11'(e * 17'sd8));
        else if (e >= 17'sd160 && e <= 17'sd240)
            n_grade.gp = 9'd256;
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_grade = r_grade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_grade <= n_grade;
        end
    end

endmodule

@@ hdl/flc_fifo.sv @@
module flc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  flc_pkg::t_grade i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output flc_pkg::t_grade o_data
);

    flc_pkg::t_grade r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 2'd1;
            if (pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_data;
    end

endmodule

@@ hdl/flc_back.sv @@
module flc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  flc_pkg::t_grade    i_grade,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_opening,
    output logic               o_valid_res
);

    localparam int NS = flc_pkg::NSTG;
    localparam int ND = flc_pkg::Q_W;
    localparam int NW = flc_pkg::NUM_W;
    localparam int DW = flc_pkg::DEN_W;

    logic adv;

    // centroid accumulation stages
    logic                 r_sv   [NS];
    flc_pkg::t_grade      r_sg   [NS];
    logic signed [NW-1:0] r_num  [NS];
    logic [DW-1:0]        r_den  [NS];

    // long division stages
    logic                 r_dv   [ND];
    logic [DW-1:0]        r_rem  [ND];
    logic [ND-1:0]        r_lo   [ND];
    logic [ND-1:0]        r_q    [ND];
    logic [DW-1:0]        r_dd   [ND];
    logic                 r_neg  [ND];
    logic                 r_zero [ND];

    logic                 r_ov;
    logic signed [15:0]   r_open;
    logic                 r_vres;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && i_valid;

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_sum
            logic                 in_v;
            flc_pkg::t_grade      in_g;
            logic signed [NW-1:0] in_num;
            logic [DW-1:0]        in_den;
            logic signed [NW-1:0] n_num;
            logic [DW-1:0]        n_den;

            if (s == 0) begin : g_first
                assign in_v   = i_valid;
                assign in_g   = i_grade;
                assign in_num = '0;
                assign in_den = '0;
            end else begin : g_next
                assign in_v   = r_sv[s-1];
                assign in_g   = r_sg[s-1];
                assign in_num = r_num[s-1];
                assign in_den = r_den[s-1];
            end

            always_comb begin
                logic [8:0] c;
                logic [8:0] o;
                logic [8:0] w;
                n_num = in_num;
                n_den = in_den;
                for (int i = 0; i < flc_pkg::CHUNK; i++) begin
                    if (s * flc_pkg::CHUNK + i < flc_pkg::NPTS) begin
                        c = flc_pkg::set_close(flc_pkg::pt(s * flc_pkg::CHUNK + i));
                        o = flc_pkg::set_open(flc_pkg::pt(s * flc_pkg::CHUNK + i));
                        w = flc_pkg::max9(
                                flc_pkg::min9(flc_pkg::max9(in_g.gn, in_g.gz), c),
                                flc_pkg::min9(in_g.gp, o));
                        n_num = n_num + NW'(NW'(flc_pkg::pt(s * flc_pkg::CHUNK + i))
                                            * NW'(w));
                        n_den = n_den + DW'(w);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[s] <= 1'b0;
                end else if (adv) begin
                    r_sv[s] <= in_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sg[s]  <= in_g;
                    r_num[s] <= n_num;
                    r_den[s] <= n_den;
                end
            end
        end

        // quotient < 2^Q_W since the centroid lies within the percent range,
        // so the top of |num|*256 already sits below the divisor
        for (s = 0; s < ND; s++) begin : g_div
            logic          in_v;
            logic [DW-1:0] in_rem;
            logic [ND-1:0] in_lo;
            logic [ND-1:0] in_q;
            logic [DW-1:0] in_dd;
            logic          in_neg;
            logic          in_zero;
            logic [DW:0]   t;
            logic          ge;

            if (s == 0) begin : g_first
                logic [NW-1:0] mag;
                assign mag     = r_num[NS-1][NW-1] ? NW'(-r_num[NS-1]) : NW'(r_num[NS-1]);
                assign in_v    = r_sv[NS-1];
                assign in_rem  = DW'(mag >> 7);
                assign in_lo   = {mag[6:0], 8'b0};
                assign in_q    = '0;
                assign in_dd   = r_den[NS-1];
                assign in_neg  = r_num[NS-1][NW-1];
                assign in_zero = (r_den[NS-1] == '0);
            end else begin : g_next
                assign in_v    = r_dv[s-1];
                assign in_rem  = r_rem[s-1];
                assign in_lo   = r_lo[s-1];
                assign in_q    = r_q[s-1];
                assign in_dd   = r_dd[s-1];
                assign in_neg  = r_neg[s-1];
                assign in_zero = r_zero[s-1];
            end

            assign t  = {in_rem, in_lo[ND-1]};
            assign ge = (t >= {1'b0, in_dd});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[s] <= 1'b0;
                end else if (adv) begin
                    r_dv[s] <= in_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rem[s]  <= ge ? DW'(t - {1'b0, in_dd}) : DW'(t);
                    r_lo[s]   <= {in_lo[ND-2:0], 1'b0};
                    r_q[s]    <= {in_q[ND-2:0], ge};
                    r_dd[s]   <= in_dd;
                    r_neg[s]  <= in_neg;
                    r_zero[s] <= in_zero;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_zero[ND-1]) begin
                r_open <= '0;
                r_vres <= 1'b0;
            end else begin
                r_open <= r_neg[ND-1] ? -$signed({1'b0, r_q[ND-1]})
                                      : $signed({1'b0, r_q[ND-1]});
                r_vres <= 1'b1;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_opening   = r_open;
    assign o_valid_res = r_vres;

endmodule

@@ hdl/fuzzy_level_controller_top.sv @@
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_current_level
// out       output     o_out_valid / i_out_ready    o_opening, o_valid_res
// cfg       APB        psel penable pwrite pready   paddr, pwdata, prdata
//
// One level sample per cycle while the queue has room. Path: front register, queue,
// accumulation and divider pipelines, output register. Throughput is set by those
// two pipelines, both stepping one transfer per cycle. A 4-deep queue splits grading
// from defuzzifying. Synchronous active-low reset clears valid bits and r_target.
// A stalled output holds the whole back pipeline; the front keeps filling the queue.
module fuzzy_level_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_current_level,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_opening,
    output logic               o_valid_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "fuzzy_level_controller_top_defines.svh"

    logic signed [15:0] r_target;
    logic               f_valid;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    flc_pkg::t_grade    f_grade;
    flc_pkg::t_grade    q_grade;

    assign pready = 1'b1;
    assign prdata = (paddr == flc_pkg::REG_TARGET) ? 32'(r_target) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (psel && penable && pwrite && paddr == flc_pkg::REG_TARGET) begin
            r_target <= pwdata[15:0];
        end
    end

    flc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_target(r_target),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_level (i_current_level),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_grade (f_grade)
    );

    flc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_valid),
        .i_data (f_grade),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (q_grade)
    );

    flc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!q_empty),
        .o_pop      (q_pop),
        .i_grade    (q_grade),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_opening  (o_opening),
        .o_valid_res(o_valid_res)
    );

    `FLC_ASSERT_NOW(a_open_range, o_out_valid && o_valid_res,
        o_opening <= 16'sd25600 && o_opening >= -16'sd25600, "opening out of range")
    `FLC_ASSERT_NOW(a_no_fire_zero, o_out_valid && !o_valid_res,
        o_opening == 16'sd0, "opening nonzero with no rule fired")
    `FLC_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && paddr == flc_pkg::REG_TARGET,
        r_target == $past(pwdata[15:0]), "target write lost")

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1830;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_current_level = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_opening;
    logic               o_valid_res;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    typedef struct {
        logic signed [15:0] opening;
        logic               valid_res;
    } opening_t;

    // directed rows: target, level, check typed value, typed value
    typedef struct {
        logic signed [15:0] target;
        logic signed [15:0] level;
        bit                 typed;
        logic signed [15:0] opening;
        logic               valid_res;
    } row_t;

    opening_t           expected_q[$];
    logic signed [15:0] target_sh = '0;
    int                 errors = 0;
    int                 cycles = 0;
    bit                 out_calm = 1'b0;
    bit                 long_hold = 1'b0;

    fuzzy_level_controller_top u_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int grade_n(int e);
        if (e >= -240 && e <= -160) return 256;
        if (e > -160 && e < 0) return ((-e) * 8) / 5;
        return 0;
    endfunction

    function automatic int grade_z(int e);
        if (e > -80 && e <= 0) return ((80 + e) * 16) / 5;
        if (e > 0 && e < 80) return ((80 - e) * 16) / 5;
        return 0;
    endfunction

    function automatic int grade_p(int e);
        if (e > 0 && e < 160) return (e * 8) / 5;
        if (e >= 160 && e <= 240) return 256;
        return 0;
    endfunction

    function automatic int close_at(int p);
        if (p > -25 && p <= 0) return ((25 + p) * 256) / 25;
        if (p > 0 && p < 25) return ((25 - p) * 256) / 25;
        return 0;
    endfunction

    function automatic int open_at(int p);
        if (p > 0 && p < 50) return (p * 256) / 50;
        if (p >= 50) return 256;
        return 0;
    endfunction

    function automatic int imin(int a, int b);
        return a < b ? a : b;
    endfunction

    function automatic int imax(int a, int b);
        return a > b ? a : b;
    endfunction

    function automatic opening_t centroid(logic signed [15:0] tgt, logic signed [15:0] lvl);
        int       e, gn, gz, gp, w, stp, p;
        longint   num, den, r;
        opening_t o;
        e = int'(tgt) - int'(lvl);
        gn = grade_n(e);
        gz = grade_z(e);
        gp = grade_p(e);
        stp = (flc_pkg::OPEN_STEP < 1) ? 1 : flc_pkg::OPEN_STEP;
        num = 0;
        den = 0;
        for (p = flc_pkg::OPEN_LOW; p <= flc_pkg::OPEN_HIGH; p += stp) begin
            w = imax(imin(gn, close_at(p)), imin(gz, close_at(p)));
            w = imax(w, imin(gp, open_at(p)));
            num += longint'(p) * w;
            den += w;
        end
        if (den == 0) begin
            o.opening = '0;
            o.valid_res = 1'b0;
            return o;
        end
        r = (num < 0) ? -(((-num) * 256) / den) : (num * 256) / den;
        if (r > 25600) r = 25600;
        if (r < -25600) r = -25600;
        o.opening = 16'(r);
        o.valid_res = 1'b1;
        return o;
    endfunction

    task automatic set_target(logic signed [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= flc_pkg::REG_TARGET;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        target_sh = v;
    endtask

    // valid stays high between back-to-back transfers; this task drops it only for a gap
    task automatic send_level(logic signed [15:0] lvl, bit gaps);
        if (gaps && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_current_level <= lvl;
        do @(posedge i_clk); while (!o_in_ready);
        expected_q.push_back(centroid(target_sh, lvl));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // receiver side
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!out_calm && $urandom_range(3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        opening_t exp_o;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer opening=%0d valid_res=%0b",
                         $time, o_opening, o_valid_res);
                errors++;
            end else begin
                exp_o = expected_q.pop_front();
                if (o_opening !== exp_o.opening) begin
                    $display("%0t: opening expected %0d actual %0d",
                             $time, exp_o.opening, o_opening);
                    errors++;
                end
                if (o_valid_res !== exp_o.valid_res) begin
                    $display("%0t: valid_res expected %0b actual %0b",
                             $time, exp_o.valid_res, o_valid_res);
                    errors++;
                end
            end
        end
    end

    row_t rows[] = '{
        '{16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd241, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, -16'sd241, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd240, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, -16'sd240, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd160, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, -16'sd160, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd80, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, -16'sd80, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd1, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, -16'sd1, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sh7fff, 1'b1, 16'sd0, 1'b0},
        '{16'sd0, -16'sd32768, 1'b1, 16'sd0, 1'b0},
        '{16'sh7fff, -16'sd32768, 1'b1, 16'sd0, 1'b0},
        '{-16'sd32768, 16'sh7fff, 1'b1, 16'sd0, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 1'b0},
        '{16'sh7fff, 16'sh7f00, 1'b0, 16'sd0, 1'b0},
        '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0, 1'b0},
        '{-16'sd32768, -16'sd32700, 1'b0, 16'sd0, 1'b0},
        '{16'sd100, 16'sd0, 1'b0, 16'sd0, 1'b0},
        '{16'sd100, 16'sd250, 1'b0, 16'sd0, 1'b0},
        '{16'sd100, -16'sd200, 1'b1, 16'sd0, 1'b0}
    };

    initial begin
        logic signed [15:0] tgt, lvl;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].target !== target_sh) begin
                drain();
                set_target(rows[k].target);
            end
            send_level(rows[k].level, 1'b1);
            if (rows[k].typed) begin
                expected_q[expected_q.size() - 1].opening = rows[k].opening;
                expected_q[expected_q.size() - 1].valid_res = rows[k].valid_res;
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 300 == 0) begin
                drain();
                case ((n / 300) % 4)
                    0: tgt = 16'sh7fff;
                    1: tgt = -16'sd32768;
                    default: tgt = 16'($urandom);
                endcase
                set_target(tgt);
            end
            if (n == 500) long_hold = 1'b1;
            if (n == N_RANDOM - 200) out_calm = 1'b1;
            // mostly inside the active band, where rules fire
            case ($urandom_range(9))
                0: lvl = 16'($urandom);
                1: lvl = 16'(int'(tgt) + $urandom_range(0, 2000) - 1000);
                default: lvl = 16'(int'(tgt) + $urandom_range(0, 500) - 250);
            endcase
            send_level(lvl, n < N_RANDOM - 200);
        end
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/flc_pkg.sv
hdl/flc_front.sv
hdl/flc_fifo.sv
hdl/flc_back.sv
hdl/fuzzy_level_controller_top.sv
tb/testbench.sv
